### design/tcaeq_pkg.sv
// Types and constants shared by the two-class admission ECN queue.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package tcaeq_pkg;

    localparam int LEN_W   = 14;
    localparam int TAG_W   = 16;
    localparam int RND_W   = 31;
    localparam int LIM_W   = 24;
    localparam int ECN_W   = 25;
    localparam int WGT_W   = 17;
    localparam int BYTES_W = 25;
    localparam int RC_W    = 18;
    localparam int CFG_W   = 25;
    localparam int IDX_W   = 3;

    localparam logic [IDX_W-1:0] REG_MAX_BYTES   = 3'd0;
    localparam logic [IDX_W-1:0] REG_SPEC_BYTES  = 3'd1;
    localparam logic [IDX_W-1:0] REG_ECN_LOW     = 3'd2;
    localparam logic [IDX_W-1:0] REG_ECN_HIGH    = 3'd3;
    localparam logic [IDX_W-1:0] REG_WEIGHT_HIGH = 3'd4;
    localparam logic [IDX_W-1:0] REG_WEIGHT_LOW  = 3'd5;

    localparam logic [LIM_W-1:0] RST_MAX_BYTES   = 24'd131072;
    localparam logic [LIM_W-1:0] RST_SPEC_BYTES  = 24'd65536;
    localparam logic [ECN_W-1:0] RST_ECN_LOW     = 25'd262144;
    localparam logic [ECN_W-1:0] RST_ECN_HIGH    = 25'd262144;
    localparam logic [WGT_W-1:0] RST_WEIGHT_HIGH = 17'd100000;
    localparam logic [WGT_W-1:0] RST_WEIGHT_LOW  = 17'd1;

    localparam logic [1:0] CLS_SPEC = 2'd0;
    localparam logic [1:0] CLS_MID  = 2'd1;
    localparam logic [1:0] CLS_HIGH = 2'd2;

    localparam logic FUNC_ARRIVE = 1'b0;

    typedef enum logic [2:0] {
        OP_HIGH,
        OP_MID,
        OP_SPEC,
        OP_DROP,
        OP_DONE
    } op_t;

    typedef enum logic [1:0] {
        SRV_IDLE,
        SRV_HIGH,
        SRV_LOW
    } srv_t;

    typedef struct packed {
        logic             func;
        logic [1:0]       traffic_class;
        logic [LEN_W-1:0] pkt_bytes;
        logic [TAG_W-1:0] pkt_tag;
        logic [RND_W-1:0] rand_value;
    } item_t;

    typedef struct packed {
        logic             is_departure;
        logic             admitted;
        logic [TAG_W-1:0] dep_tag;
        logic [LEN_W-1:0] dep_bytes;
        logic             dep_from_high;
        logic             ecn_marked;
        logic             serving;
        logic [LEN_W-1:0] next_bytes;
    } result_t;

    typedef struct packed {
        op_t              op;
        logic [LEN_W-1:0] len;
        logic [TAG_W-1:0] tag;
        logic [RND_W-1:0] rnd;
    } cmd_t;

    typedef struct packed {
        logic [LIM_W-1:0] max_bytes;
        logic [LIM_W-1:0] speculative_bytes;
        logic [ECN_W-1:0] ecn_low_bytes;
        logic [ECN_W-1:0] ecn_high_bytes;
        logic [WGT_W-1:0] weight_high;
        logic [WGT_W-1:0] weight_low;
    } cfg_t;

    // front-to-back handshake of the command queue
    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmdq_t;

endpackage

### design/tcaeq_front.sv
// Front end: accepts input beats, decodes the operation and holds a
// two-entry command queue. Depends on tcaeq_pkg.
`timescale 1ns / 1ps

module tcaeq_front
    import tcaeq_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  item_t item,
    output logic  busy,
    input  logic  pop,
    output cmdq_t head,
    output logic  empty
);

    cmd_t       ent_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;
    cmd_t       dec;

    always_comb
    begin
        dec.len = item.pkt_bytes;
        dec.tag = item.pkt_tag;
        dec.rnd = item.rand_value;
        if (item.func != FUNC_ARRIVE)
        begin
            dec.op = OP_DONE;
        end
        else
        begin
            unique case (item.traffic_class)
                CLS_HIGH: dec.op = OP_HIGH;
                CLS_MID:  dec.op = OP_MID;
                CLS_SPEC: dec.op = OP_SPEC;
                default:  dec.op = OP_DROP;
            endcase
        end
    end

    assign busy = (cnt_reg == 2'd2);
    assign push = start && !busy;
    assign empty = (cnt_reg == 2'd0);

    assign head.valid = !empty;
    assign head.cmd   = ent_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= dec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

### design/tcaeq_div.sv
// Restoring divider, one quotient bit per cycle, for the ECN probability.
// Quotient is known to fit 31 bits (numerator below den * 2^31). Uses tcaeq_pkg.
`timescale 1ns / 1ps

module tcaeq_div
    import tcaeq_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [ECN_W-1:0] num_hi,
    input  logic [RND_W-1:0] num_lo,
    input  logic [ECN_W-1:0] den,
    output logic             done,
    output logic [RND_W-1:0] quot
);

    localparam int CNT_W = $clog2(RND_W + 1);

    logic [ECN_W-1:0] rem_reg;
    logic [RND_W-1:0] lo_reg;
    logic [RND_W-1:0] quot_reg;
    logic [ECN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;
    logic [ECN_W:0]   trial;
    logic [ECN_W:0]   diff;
    logic             fits;

    assign trial = {rem_reg, lo_reg[RND_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = (trial >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            // last quotient bit lands on the step where the count leaves 1
            done_reg <= !start && (cnt_reg == CNT_W'(1));
            if (start)
            begin
                cnt_reg <= CNT_W'(RND_W);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= num_hi;
            lo_reg   <= num_lo;
            den_reg  <= den;
            quot_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg  <= fits ? diff[ECN_W-1:0] : trial[ECN_W-1:0];
            lo_reg   <= {lo_reg[RND_W-2:0], 1'b0};
            quot_reg <= {quot_reg[RND_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

### design/tcaeq_back.sv
// Back end: the two packet FIFOs, byte counts, WRR pick, ECN decision and
// the result register. Depends on tcaeq_pkg and tcaeq_div.
`timescale 1ns / 1ps

module tcaeq_back
    import tcaeq_pkg::*;
#(
    parameter int FIFO_DEPTH = 256,
    parameter int TAG_BITS   = 16
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  cmdq_t   head,
    output logic    pop,
    output logic    done,
    output result_t result
);

    localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CW = $clog2(FIFO_DEPTH + 1);
    localparam int TW = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;
    localparam int EW = TW + LEN_W;

    typedef enum logic [5:0] {
        ST_WAIT = 6'b000001,
        ST_MARK = 6'b000010,
        ST_DIV  = 6'b000100,
        ST_SEL  = 6'b001000,
        ST_LOAD = 6'b010000,
        ST_EMIT = 6'b100000
    } st_t;

    st_t              st_reg;
    srv_t             srv_reg;
    logic [AW-1:0]    hi_head_reg, hi_tail_reg, lo_head_reg, lo_tail_reg;
    logic [CW-1:0]    hi_cnt_reg, lo_cnt_reg;
    logic [BYTES_W-1:0] hi_bytes_reg, lo_bytes_reg;
    logic [RC_W-1:0]  rc_reg;
    logic [TW-1:0]    cur_tag_reg;
    logic [LEN_W-1:0] cur_len_reg;
    logic [RND_W-1:0] rnd_reg;
    result_t          res_reg;
    logic             done_reg;

    logic [EW-1:0]    hi_mem [FIFO_DEPTH];
    logic [EW-1:0]    lo_mem [FIFO_DEPTH];
    logic [EW-1:0]    hi_rd, lo_rd;
    logic             hi_we, lo_we;
    logic [EW-1:0]    wr_word;

    logic [BYTES_W:0] hi_sum, lo_sum;
    logic             hi_ok, lo_ok;
    logic [LIM_W-1:0] lo_limit;

    logic [RC_W-1:0]  wsum, rc_inc, rc_new;
    logic             hne, lne;

    logic [ECN_W-1:0] qdiff, span;
    logic [ECN_W+RND_W-1:0] num;
    logic             div_start, div_done;
    logic [RND_W-1:0] div_quot;

    result_t          wait_res;
    st_t              wait_st;

    function automatic logic [AW-1:0] advance(input logic [AW-1:0] p);
        return (p == AW'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // admission checks against the current byte counts
    assign hi_sum   = {1'b0, hi_bytes_reg} + (BYTES_W+1)'(head.cmd.len);
    assign lo_sum   = {1'b0, lo_bytes_reg} + (BYTES_W+1)'(head.cmd.len);
    assign lo_limit = (head.cmd.op == OP_MID) ? cfg.max_bytes : cfg.speculative_bytes;
    assign hi_ok    = (hi_cnt_reg != CW'(FIFO_DEPTH))
                      && (hi_sum <= (BYTES_W+1)'(cfg.max_bytes));
    assign lo_ok    = (lo_cnt_reg != CW'(FIFO_DEPTH))
                      && (lo_sum < (BYTES_W+1)'(lo_limit));

    assign pop     = (st_reg == ST_WAIT) && head.valid;
    assign wr_word = {TW'(head.cmd.tag), head.cmd.len};
    assign hi_we   = pop && (head.cmd.op == OP_HIGH) && hi_ok;
    assign lo_we   = pop && ((head.cmd.op == OP_MID) || (head.cmd.op == OP_SPEC)) && lo_ok;

    // result and next state for the beat taken in ST_WAIT
    always_comb
    begin
        wait_res = '0;
        wait_st  = ST_EMIT;
        if (hi_we || lo_we)
        begin
            wait_res.admitted = 1'b1;
            if (srv_reg == SRV_IDLE)
            begin
                wait_st = ST_SEL;
            end
        end
        else if ((head.cmd.op == OP_DONE) && (srv_reg != SRV_IDLE))
        begin
            wait_res.is_departure  = 1'b1;
            wait_res.dep_tag       = TAG_W'(cur_tag_reg);
            wait_res.dep_bytes     = cur_len_reg;
            wait_res.dep_from_high = (srv_reg == SRV_HIGH);
            wait_st                = ST_MARK;
        end
    end

    // WRR pick
    assign hne    = (hi_cnt_reg != '0);
    assign lne    = (lo_cnt_reg != '0);
    assign wsum   = {1'b0, cfg.weight_high} + {1'b0, cfg.weight_low};
    assign rc_inc = rc_reg + 1'b1;
    assign rc_new = (rc_inc >= wsum) ? '0 : rc_inc;

    // 0x7FFFFFFF * d == (d << 31) - d
    assign qdiff = lo_bytes_reg - cfg.ecn_low_bytes;
    assign span  = cfg.ecn_high_bytes - cfg.ecn_low_bytes;
    assign num   = {qdiff, {RND_W{1'b0}}} - (ECN_W+RND_W)'(qdiff);
    assign div_start = (st_reg == ST_MARK)
                       && !(lo_bytes_reg > cfg.ecn_high_bytes)
                       && (lo_bytes_reg > cfg.ecn_low_bytes);

    tcaeq_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .num_hi (num[ECN_W+RND_W-1:RND_W]),
        .num_lo (num[RND_W-1:0]),
        .den    (span),
        .done   (div_done),
        .quot   (div_quot)
    );

    always_ff @(posedge clk)
    begin
        if (hi_we)
        begin
            hi_mem[hi_tail_reg] <= wr_word;
        end
        if (lo_we)
        begin
            lo_mem[lo_tail_reg] <= wr_word;
        end
        hi_rd <= hi_mem[hi_head_reg];
        lo_rd <= lo_mem[lo_head_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg       <= ST_WAIT;
            srv_reg      <= SRV_IDLE;
            hi_head_reg  <= '0;
            hi_tail_reg  <= '0;
            lo_head_reg  <= '0;
            lo_tail_reg  <= '0;
            hi_cnt_reg   <= '0;
            lo_cnt_reg   <= '0;
            hi_bytes_reg <= '0;
            lo_bytes_reg <= '0;
            rc_reg       <= '0;
            cur_tag_reg  <= '0;
            cur_len_reg  <= '0;
            rnd_reg      <= '0;
            res_reg      <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            done_reg <= (st_reg == ST_EMIT);
            unique case (st_reg)
                ST_WAIT:
                begin
                    if (head.valid)
                    begin
                        res_reg <= wait_res;
                        rnd_reg <= head.cmd.rnd;
                        st_reg  <= wait_st;
                        if (hi_we)
                        begin
                            hi_tail_reg  <= advance(hi_tail_reg);
                            hi_cnt_reg   <= hi_cnt_reg + 1'b1;
                            hi_bytes_reg <= hi_sum[BYTES_W-1:0];
                        end
                        else if (lo_we)
                        begin
                            lo_tail_reg  <= advance(lo_tail_reg);
                            lo_cnt_reg   <= lo_cnt_reg + 1'b1;
                            lo_bytes_reg <= lo_sum[BYTES_W-1:0];
                        end
                        else if (wait_res.is_departure)
                        begin
                            if (srv_reg == SRV_HIGH)
                            begin
                                hi_head_reg  <= advance(hi_head_reg);
                                hi_cnt_reg   <= hne ? hi_cnt_reg - 1'b1 : hi_cnt_reg;
                                hi_bytes_reg <= hi_bytes_reg - BYTES_W'(cur_len_reg);
                            end
                            else
                            begin
                                lo_head_reg  <= advance(lo_head_reg);
                                lo_cnt_reg   <= lne ? lo_cnt_reg - 1'b1 : lo_cnt_reg;
                                lo_bytes_reg <= lo_bytes_reg - BYTES_W'(cur_len_reg);
                            end
                            srv_reg <= SRV_IDLE;
                        end
                    end
                end
                ST_MARK:
                begin
                    if (lo_bytes_reg > cfg.ecn_high_bytes)
                    begin
                        res_reg.ecn_marked <= 1'b1;
                        st_reg <= ST_SEL;
                    end
                    else if (lo_bytes_reg > cfg.ecn_low_bytes)
                    begin
                        st_reg <= ST_DIV;
                    end
                    else
                    begin
                        st_reg <= ST_SEL;
                    end
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        res_reg.ecn_marked <= (rnd_reg < div_quot);
                        st_reg <= ST_SEL;
                    end
                end
                ST_SEL:
                begin
                    if (hne && lne)
                    begin
                        rc_reg  <= rc_new;
                        srv_reg <= (rc_new < RC_W'(cfg.weight_high)) ? SRV_HIGH : SRV_LOW;
                        st_reg  <= ST_LOAD;
                    end
                    else if (hne)
                    begin
                        srv_reg <= SRV_HIGH;
                        st_reg  <= ST_LOAD;
                    end
                    else if (lne)
                    begin
                        srv_reg <= SRV_LOW;
                        st_reg  <= ST_LOAD;
                    end
                    else
                    begin
                        srv_reg <= SRV_IDLE;
                        st_reg  <= ST_EMIT;
                    end
                end
                ST_LOAD:
                begin
                    if (srv_reg == SRV_HIGH)
                    begin
                        cur_tag_reg <= hi_rd[EW-1:LEN_W];
                        cur_len_reg <= hi_rd[LEN_W-1:0];
                    end
                    else
                    begin
                        cur_tag_reg <= lo_rd[EW-1:LEN_W];
                        cur_len_reg <= lo_rd[LEN_W-1:0];
                    end
                    st_reg <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    {res_reg.serving, res_reg.next_bytes} <=
                        (srv_reg != SRV_IDLE) ? {1'b1, cur_len_reg} : '0;
                    st_reg <= ST_WAIT;
                end
                default:
                begin
                    st_reg <= ST_WAIT;
                end
            endcase
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

### design/two_class_admission_ecn_queue.sv
// Flow: an arrival, or a completion while idle, runs ST_WAIT and ST_EMIT (adding
// ST_SEL and ST_LOAD when an arrival starts service); a completion runs ST_WAIT,
// ST_MARK, ST_DIV when the ECN probability runs the 31-step divider, ST_SEL, then
// ST_LOAD unless both FIFOs end empty, and ST_EMIT. One beat is taken per result.
// Reset (rst_n, async low) empties both FIFOs and the command queue and loads the
// register defaults; the FIFO stores are not cleared. The receiver cannot stall.
`timescale 1ns / 1ps

module two_class_admission_ecn_queue
    import tcaeq_pkg::*;
#(
    parameter int FIFO_DEPTH = 256,
    parameter int TAG_BITS   = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  item_t            item,
    output logic             done,
    output result_t          result,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_index,
    input  logic [CFG_W-1:0] wr_data
);

    // Front: decode of func / traffic_class into a queued op. Back: FIFOs,
    // WRR service pick, ECN divider and the result register. The queue
    // between them lets a new beat land while the back end is dividing.

    cfg_t  cfg_reg;
    cmdq_t q_head;
    logic  q_empty;
    logic  q_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_bytes         <= RST_MAX_BYTES;
            cfg_reg.speculative_bytes <= RST_SPEC_BYTES;
            cfg_reg.ecn_low_bytes     <= RST_ECN_LOW;
            cfg_reg.ecn_high_bytes    <= RST_ECN_HIGH;
            cfg_reg.weight_high       <= RST_WEIGHT_HIGH;
            cfg_reg.weight_low        <= RST_WEIGHT_LOW;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_MAX_BYTES:   cfg_reg.max_bytes         <= wr_data[LIM_W-1:0];
                REG_SPEC_BYTES:  cfg_reg.speculative_bytes <= wr_data[LIM_W-1:0];
                REG_ECN_LOW:     cfg_reg.ecn_low_bytes     <= wr_data[ECN_W-1:0];
                REG_ECN_HIGH:    cfg_reg.ecn_high_bytes    <= wr_data[ECN_W-1:0];
                REG_WEIGHT_HIGH: cfg_reg.weight_high       <= wr_data[WGT_W-1:0];
                REG_WEIGHT_LOW:  cfg_reg.weight_low        <= wr_data[WGT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    tcaeq_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .item  (item),
        .busy  (busy),
        .pop   (q_pop),
        .head  (q_head),
        .empty (q_empty)
    );

    tcaeq_back #(
        .FIFO_DEPTH (FIFO_DEPTH),
        .TAG_BITS   (TAG_BITS)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .head   (q_head),
        .pop    (q_pop),
        .done   (done),
        .result (result)
    );

    // result strobe is a single cycle, never back to back
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held two cycles");

    // back end never pops an empty queue
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("pop from empty command queue");

    // a departure beat never reports an admission
    a_dep_not_adm: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.is_departure) |-> !result.admitted)
        else $error("departure flagged as admitted");

    // an idle result carries no length
    a_idle_len: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.serving) |-> (result.next_bytes == '0))
        else $error("next_bytes set while idle");

endmodule

### verif/two_class_admission_ecn_queue_tb.sv
// Self-checking testbench for two_class_admission_ecn_queue: directed table, then random phases.
// Depends on tcaeq_pkg and the design top; holds its own model of queues, WRR and ECN marking.
`timescale 1ns / 1ps

module two_class_admission_ecn_queue_tb;
    import tcaeq_pkg::*;

    localparam logic FUNC_DONE   = 1'b1;
    localparam int   QDEPTH      = 256;
    localparam int   RAND_ITEMS  = 1850;
    localparam int   NUM_PHASES  = 7;
    localparam int   CYCLE_LIMIT = 1000000;
    localparam int   DRAIN_WAIT  = 40;

    typedef struct {
        logic [TAG_W-1:0] tag;
        logic [LEN_W-1:0] len;
    } pkt_t;

    typedef struct {
        item_t   it;
        bit      typed;     // expectation read off directly
        result_t want;
    } dir_row_t;

    typedef struct {
        cfg_t cfg;
        int   arr_pct;      // share of arrivals among beats
        int   max_len;      // usual upper bound on packet length
    } phase_t;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    item_t            item;
    logic             done;
    result_t          result;
    logic             wr_en;
    logic [IDX_W-1:0] wr_index;
    logic [CFG_W-1:0] wr_data;

    two_class_admission_ecn_queue u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .item     (item),
        .done     (done),
        .result   (result),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    // ---------------------------------------------------------------
    // Model state: packet queues, byte totals, WRR counter, service.
    // ---------------------------------------------------------------
    pkt_t               hi_pkts[$];
    pkt_t               lo_pkts[$];
    logic [BYTES_W-1:0] hi_held;
    logic [BYTES_W-1:0] lo_held;
    logic [RC_W-1:0]    wrr_count;
    srv_t               in_service;
    cfg_t               regs;

    result_t pending_results[$];

    int errors;
    int cycles;
    int beats_sent;
    int results_seen;
    int n_admit, n_drop, n_depart, n_marked, n_full_drop;
    int sender_idle_pct;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hard stop if the block hangs.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d results still expected", $time, pending_results.size());
            $display("two_class_admission_ecn_queue_tb: done, errors");
            $finish;
        end
    end

    // Choose the queue to serve when idle; WRR applies only when both hold packets.
    task automatic pick_service();
        logic [RC_W-1:0] sum;
        begin
            sum = regs.weight_high + regs.weight_low;
            if (hi_pkts.size() != 0 && lo_pkts.size() != 0)
            begin
                wrr_count = wrr_count + 1'b1;
                if (wrr_count >= sum)
                    wrr_count = '0;
                in_service = (wrr_count < regs.weight_high) ? SRV_HIGH : SRV_LOW;
            end
            else if (hi_pkts.size() != 0)
                in_service = SRV_HIGH;
            else if (lo_pkts.size() != 0)
                in_service = SRV_LOW;
            else
                in_service = SRV_IDLE;
        end
    endtask

    // RED-style mark on the low bytes left after the departure.
    function automatic bit ecn_decision(logic [RND_W-1:0] rnd);
        logic [63:0] q;
        logic [63:0] p;
        begin
            q = lo_held;
            ecn_decision = 1'b0;
            if (q > regs.ecn_high_bytes)
                ecn_decision = 1'b1;
            else if (q > regs.ecn_low_bytes)
            begin
                p = (64'h7FFF_FFFF * (q - regs.ecn_low_bytes)) /
                    (64'(regs.ecn_high_bytes) - regs.ecn_low_bytes);
                ecn_decision = (64'(rnd) < p);
            end
        end
    endfunction

    // Advance the queue model by one beat and produce its result.
    task automatic queue_model_step(input item_t it, output result_t r);
        pkt_t             pk;
        logic [63:0]      limit;
        bit               is_hi;
        begin
            r = '0;
            if (it.func == FUNC_ARRIVE)
            begin
                pk.tag = it.pkt_tag;
                pk.len = it.pkt_bytes;
                if (it.traffic_class == CLS_HIGH)
                begin
                    if (hi_pkts.size() >= QDEPTH)
                        n_full_drop++;
                    else if (64'(hi_held) + it.pkt_bytes <= regs.max_bytes)
                    begin
                        hi_pkts.push_back(pk);
                        hi_held = hi_held + it.pkt_bytes;
                        r.admitted = 1'b1;
                    end
                end
                else if (it.traffic_class == CLS_MID || it.traffic_class == CLS_SPEC)
                begin
                    limit = (it.traffic_class == CLS_MID) ? regs.max_bytes
                                                          : regs.speculative_bytes;
                    if (lo_pkts.size() >= QDEPTH)
                        n_full_drop++;
                    else if (64'(lo_held) + it.pkt_bytes < limit)
                    begin
                        lo_pkts.push_back(pk);
                        lo_held = lo_held + it.pkt_bytes;
                        r.admitted = 1'b1;
                    end
                end
                if (r.admitted) n_admit++; else n_drop++;
                if (r.admitted && in_service == SRV_IDLE)
                    pick_service();
            end
            else if (in_service != SRV_IDLE)
            begin
                is_hi = (in_service == SRV_HIGH);
                if (is_hi)
                begin
                    pk = hi_pkts.pop_front();
                    hi_held = hi_held - pk.len;
                end
                else
                begin
                    pk = lo_pkts.pop_front();
                    lo_held = lo_held - pk.len;
                end
                r.is_departure  = 1'b1;
                r.dep_tag       = pk.tag;
                r.dep_bytes     = pk.len;
                r.dep_from_high = is_hi;
                r.ecn_marked    = ecn_decision(it.rand_value);
                n_depart++;
                if (r.ecn_marked) n_marked++;
                in_service = SRV_IDLE;
                pick_service();
            end
            r.serving = (in_service != SRV_IDLE);
            if (in_service == SRV_HIGH)
                r.next_bytes = hi_pkts[0].len;
            else if (in_service == SRV_LOW)
                r.next_bytes = lo_pkts[0].len;
        end
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        begin
            if (want !== got)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            end
        end
    endtask

    // Result side: each strobe is one beat, compared with the oldest expectation.
    always @(posedge clk)
    begin
        result_t w;
        if (rst_n && done)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result beat, expected none, actual %h", $time, result);
            end
            else
            begin
                w = pending_results.pop_front();
                check_field("is_departure",  w.is_departure,  result.is_departure);
                check_field("admitted",      w.admitted,      result.admitted);
                check_field("dep_tag",       w.dep_tag,       result.dep_tag);
                check_field("dep_bytes",     w.dep_bytes,     result.dep_bytes);
                check_field("dep_from_high", w.dep_from_high, result.dep_from_high);
                check_field("ecn_marked",    w.ecn_marked,    result.ecn_marked);
                check_field("serving",       w.serving,       result.serving);
                check_field("next_bytes",    w.next_bytes,    result.next_bytes);
            end
        end
    end

    // Send one beat; start stays high across back-to-back beats.
    task automatic send_beat(input item_t it, input bit typed, input result_t want);
        result_t r;
        int      gap;
        begin
            if ($urandom_range(99) < sender_idle_pct)
            begin
                gap = $urandom_range(4, 1);
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            start <= 1'b1;
            item  <= it;
            @(posedge clk);
            while (busy)
                @(posedge clk);
            queue_model_step(it, r);
            pending_results.push_back(typed ? want : r);
            beats_sent++;
        end
    endtask

    // Registers change only with the block idle.
    task automatic load_regs(input cfg_t c);
        begin
            start <= 1'b0;
            @(posedge clk);
            while (pending_results.size() != 0)
                @(posedge clk);
            repeat (DRAIN_WAIT) @(posedge clk);
            wr_en <= 1'b1; wr_index <= REG_MAX_BYTES;   wr_data <= CFG_W'(c.max_bytes);
            @(posedge clk);
            wr_index <= REG_SPEC_BYTES;  wr_data <= CFG_W'(c.speculative_bytes);
            @(posedge clk);
            wr_index <= REG_ECN_LOW;     wr_data <= CFG_W'(c.ecn_low_bytes);
            @(posedge clk);
            wr_index <= REG_ECN_HIGH;    wr_data <= CFG_W'(c.ecn_high_bytes);
            @(posedge clk);
            wr_index <= REG_WEIGHT_HIGH; wr_data <= CFG_W'(c.weight_high);
            @(posedge clk);
            wr_index <= REG_WEIGHT_LOW;  wr_data <= CFG_W'(c.weight_low);
            @(posedge clk);
            wr_en <= 1'b0;
            regs = c;
        end
    endtask

    function automatic item_t make_item(logic f, logic [1:0] cls, int len,
                                        logic [TAG_W-1:0] tag, logic [RND_W-1:0] rnd);
        item_t it;
        begin
            it.func          = f;
            it.traffic_class = cls;
            it.pkt_bytes     = LEN_W'(len);
            it.pkt_tag       = tag;
            it.rand_value    = rnd;
            make_item = it;
        end
    endfunction

    function automatic item_t random_item(int arr_pct, int max_len);
        item_t it;
        int    c;
        int    r;
        begin
            it.func = ($urandom_range(99) < arr_pct) ? FUNC_ARRIVE : FUNC_DONE;
            c = $urandom_range(19);
            it.traffic_class = (c == 0) ? 2'd3 : 2'(c % 3);   // class three is rare
            it.pkt_bytes = ($urandom_range(9) == 0) ? LEN_W'($urandom_range(16383, 1))
                                                    : LEN_W'($urandom_range(max_len, 1));
            it.pkt_tag = TAG_W'($urandom);
            r = $urandom_range(9);
            it.rand_value = (r == 0) ? '0 : (r == 1) ? 31'h7FFF_FFFF : RND_W'($urandom);
            random_item = it;
        end
    endfunction

    dir_row_t dir_tab[$];
    phase_t   phases[NUM_PHASES];

    initial
    begin
        dir_row_t row;
        int       per_phase;
        int       n;
        cfg_t     dflt;

        errors = 0; cycles = 0; beats_sent = 0; results_seen = 0;
        n_admit = 0; n_drop = 0; n_depart = 0; n_marked = 0; n_full_drop = 0;
        sender_idle_pct = 15;
        rst_n    = 1'b0;
        start    = 1'b0;
        item     = '0;
        wr_en    = 1'b0;
        wr_index = '0;
        wr_data  = '0;

        dflt = '{RST_MAX_BYTES, RST_SPEC_BYTES, RST_ECN_LOW, RST_ECN_HIGH,
                 RST_WEIGHT_HIGH, RST_WEIGHT_LOW};
        regs       = dflt;
        hi_held    = '0;
        lo_held    = '0;
        wrr_count  = '0;
        in_service = SRV_IDLE;

        // Directed table at reset settings.
        // completion while idle: all zero
        row = '{make_item(FUNC_DONE, CLS_HIGH, 16383, 16'hFFFF, 31'h7FFF_FFFF), 1'b1, '0};
        dir_tab.push_back(row);
        // class three is always dropped
        row = '{make_item(FUNC_ARRIVE, 2'd3, 100, 16'h00AA, '0), 1'b1, '0};
        dir_tab.push_back(row);
        // longest high packet starts service
        row = '{make_item(FUNC_ARRIVE, CLS_HIGH, 16383, 16'hFFFF, '0), 1'b1,
                result_t'{1'b0, 1'b1, 16'd0, 14'd0, 1'b0, 1'b0, 1'b1, 14'd16383}};
        dir_tab.push_back(row);
        // shortest mid packet queues behind it
        row = '{make_item(FUNC_ARRIVE, CLS_MID, 1, 16'h0000, '0), 1'b1,
                result_t'{1'b0, 1'b1, 16'd0, 14'd0, 1'b0, 1'b0, 1'b1, 14'd16383}};
        dir_tab.push_back(row);
        // the rest run through the model
        dir_tab.push_back('{make_item(FUNC_ARRIVE, CLS_SPEC, 16383, 16'h1234, '0), 1'b0, '0});
        dir_tab.push_back('{make_item(FUNC_ARRIVE, CLS_SPEC, 16383, 16'h5678, '0), 1'b0, '0});
        dir_tab.push_back('{make_item(FUNC_ARRIVE, CLS_SPEC, 16383, 16'h9ABC, '0), 1'b0, '0});
        dir_tab.push_back('{make_item(FUNC_ARRIVE, CLS_SPEC, 16383, 16'hDEF0, '0), 1'b0, '0});
        dir_tab.push_back('{make_item(FUNC_ARRIVE, CLS_HIGH, 16383, 16'h0001, '0), 1'b0, '0});
        dir_tab.push_back('{make_item(FUNC_ARRIVE, CLS_MID, 16383, 16'h0002, '0), 1'b0, '0});
        for (int i = 0; i < 10; i++)
        begin
            dir_tab.push_back('{make_item(FUNC_ARRIVE, 2'(i % 3), 5000 + i,
                                          TAG_W'(16'h8000 + i), '0), 1'b0, '0});
            dir_tab.push_back('{make_item(FUNC_DONE, CLS_SPEC, 1, '0,
                                          (i % 2) ? 31'h7FFF_FFFF : 31'h0), 1'b0, '0});
        end

        // Random phases: defaults, narrow ECN band, all-max, lowered weights,
        // zero weights with limits out of order, all-zero limits, band again.
        phases[0] = '{dflt, 55, 16383};
        phases[1] = '{cfg_t'{24'd200000, 24'd100000, 25'd2000, 25'd60000, 17'd3, 17'd2}, 55, 4000};
        phases[2] = '{cfg_t'{24'hFF_FFFF, 24'hFF_FFFF, 25'd0, 25'h1FF_FFFF,
                             17'h1_FFFF, 17'h1_FFFF}, 85, 64};
        phases[3] = '{cfg_t'{24'd500000, 24'd300000, 25'd10000, 25'd20000, 17'd1, 17'd1}, 50, 8000};
        phases[4] = '{cfg_t'{24'd30000, 24'd50000, 25'd40000, 25'd100, 17'd0, 17'd0}, 60, 3000};
        phases[5] = '{cfg_t'{24'd0, 24'd0, 25'd0, 25'd0, 17'd1, 17'd0}, 40, 100};
        phases[6] = '{cfg_t'{24'd80000, 24'd60000, 25'd5000, 25'd70000, 17'd2, 17'd5}, 50, 6000};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i])
            send_beat(dir_tab[i].it, dir_tab[i].typed, dir_tab[i].want);

        per_phase = RAND_ITEMS / NUM_PHASES + 1;
        n = 0;
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            load_regs(phases[p].cfg);
            for (int k = 0; k < per_phase; k++)
            begin
                // sender idles 15%, then 65%, then not at all
                sender_idle_pct = (n < RAND_ITEMS / 3) ? 15 :
                                  (n < 2 * RAND_ITEMS / 3) ? 65 : 0;
                send_beat(random_item(phases[p].arr_pct, phases[p].max_len), 1'b0, '0);
                n++;
            end
        end

        start <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            errors++;
            $display("%0t: %0d expected results never arrived", $time, pending_results.size());
        end

        $display("Ran %0d beats over %0d register settings: %0d admitted, %0d dropped (%0d full).",
                 beats_sent, NUM_PHASES, n_admit, n_drop, n_full_drop);
        $display("Saw %0d result beats, %0d departures, %0d ECN marked, %0d errors.",
                 results_seen, n_depart, n_marked, errors);
        if (errors == 0)
            $display("two_class_admission_ecn_queue_tb: done, clean");
        else
            $display("two_class_admission_ecn_queue_tb: done, errors");
        $finish;
    end

endmodule
